@@ hw/rtl/srph_pkg.sv @@
`default_nettype none

package srph_pkg;

  localparam int HASH_COUNT    = 32;
  localparam int VECTOR_LENGTH = 1024;

  // Field widths
  localparam int ROW_W  = 5;
  localparam int COL_W  = 10;
  localparam int VAL_W  = 16;
  localparam int HASH_W = 32;

  // Arithmetic widths: Q2.13 x Q7.8 -> Q10.21, accumulated in Q26.21
  localparam int COEF_W = 16;
  localparam int PROD_W = 32;
  localparam int ACC_W  = 48;

  localparam int IDX_W  = (HASH_COUNT > 1) ? $clog2(HASH_COUNT) : 1;
  localparam int CMP_W  = (IDX_W > ROW_W) ? IDX_W : ROW_W;
  localparam int ADDR_W = (VECTOR_LENGTH > 1) ? $clog2(VECTOR_LENGTH) : 1;

  localparam logic FUNC_LOAD = 1'b0;
  localparam logic FUNC_ELEM = 1'b1;

  // Item travelling down the chain of cells
  typedef struct packed {
    logic                    vld;
    logic                    func;
    logic [ROW_W-1:0]        row;
    logic [COL_W-1:0]        col;
    logic signed [VAL_W-1:0] value;
    logic                    last;
    logic                    hit;
    logic [HASH_W-1:0]       hash;
  } srph_tok_t;

endpackage

`default_nettype wire

@@ hw/rtl/srph_ram.sv @@
`default_nettype none

module srph_ram #(
  parameter int WIDTH = 16,
  parameter int DEPTH = 1024
) (
  input  wire logic                                   clk_i,
  input  wire logic                                   we_i,
  input  wire logic                                   re_i,
  input  wire logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] addr_i,
  input  wire logic [WIDTH-1:0]                       wdata_i,
  output      logic [WIDTH-1:0]                       rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[addr_i] <= wdata_i;
    end
    // hold read data while no read is issued
    if (re_i) begin
      rdata_q <= mem_q[addr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

`default_nettype wire

@@ hw/rtl/srph_cell.sv @@
`default_nettype none

module srph_cell import srph_pkg::*; (
  input  wire logic              clk_i,
  input  wire logic              rst_ni,
  input  wire logic              adv_i,
  input  wire logic [IDX_W-1:0]  idx_i,
  input  wire logic [HASH_W-1:0] mask_i,
  input  wire srph_tok_t         tok_i,
  output      srph_tok_t         tok_o
);

  logic                     wr_en;
  logic                     rd_en;
  logic [ADDR_W-1:0]        addr;
  logic signed [COEF_W-1:0] coef;
  logic signed [PROD_W-1:0] prod;
  logic [ACC_W:0]           sum_wide;
  logic [ACC_W-1:0]         sum_sat;
  logic                     pos;
  srph_tok_t                tok3_d;

  srph_tok_t                s1_q;
  srph_tok_t                s2_q;
  srph_tok_t                s3_q;
  logic signed [PROD_W-1:0] p_q;
  logic [ACC_W-1:0]         acc_q;

  assign addr  = ADDR_W'(tok_i.col);
  assign wr_en = adv_i & tok_i.vld & (tok_i.func == FUNC_LOAD) & tok_i.hit &
                 (CMP_W'(tok_i.row) == CMP_W'(idx_i));
  assign rd_en = adv_i & tok_i.vld & (tok_i.func == FUNC_ELEM) & tok_i.hit;

  srph_ram #(
    .WIDTH(COEF_W),
    .DEPTH(VECTOR_LENGTH)
  ) u_ram (
    .clk_i  (clk_i),
    .we_i   (wr_en),
    .re_i   (rd_en),
    .addr_i (addr),
    .wdata_i(tok_i.value),
    .rdata_o(coef)
  );

  assign prod = coef * s1_q.value;

  // add with saturation at the 48-bit signed bounds
  always_comb begin
    sum_wide = {acc_q[ACC_W-1], acc_q} +
               {{(ACC_W + 1 - PROD_W){p_q[PROD_W-1]}}, p_q};
    if (sum_wide[ACC_W] != sum_wide[ACC_W-1]) begin
      sum_sat = sum_wide[ACC_W] ? {1'b1, {(ACC_W - 1){1'b0}}}
                                : {1'b0, {(ACC_W - 1){1'b1}}};
    end else begin
      sum_sat = sum_wide[ACC_W-1:0];
    end
    pos = ~sum_sat[ACC_W-1] & (|sum_sat);
    tok3_d = s2_q;
    if (s2_q.vld && (s2_q.func == FUNC_ELEM) && s2_q.last && pos) begin
      tok3_d.hash = s2_q.hash | mask_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_q  <= '0;
      s2_q  <= '0;
      s3_q  <= '0;
      acc_q <= '0;
    end else if (adv_i) begin
      s1_q <= tok_i;
      s2_q <= s1_q;
      s3_q <= tok3_d;
      if (s2_q.vld && (s2_q.func == FUNC_ELEM)) begin
        // clear after the last element of a vector
        acc_q <= s2_q.last ? '0 : sum_sat;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv_i) begin
      p_q <= (s1_q.vld && (s1_q.func == FUNC_ELEM) && s1_q.hit) ? prod : '0;
    end
  end

  assign tok_o = s3_q;

endmodule

`default_nettype wire

@@ hw/rtl/signed_random_projection_hash_unit.sv @@
`default_nettype none

// Channel  Direction  Handshake                Payload
// in       input      in_valid_i / in_stall_o  func, hash_select, element_index,
//                                              element_value, last
// out      output     out_valid_o / out_stall_i hash_bits
//
// One item enters per cycle while the output register is empty or not stalled.
// An item walks a chain of HASH_COUNT cells, each with the stages coefficient
// RAM read, multiply and accumulate; a hash is offered from the output register
// once its last element has left the last cell. Reset clears the accumulators
// and all valid bits; the coefficient RAMs are not cleared. A stalled, full
// output register freezes the whole chain.

module signed_random_projection_hash_unit import srph_pkg::*; (
  input  wire logic                    clk_i,
  input  wire logic                    rst_ni,
  input  wire logic                    in_valid_i,
  output      logic                    in_stall_o,
  input  wire logic                    func_i,
  input  wire logic [ROW_W-1:0]        hash_select_i,
  input  wire logic [COL_W-1:0]        element_index_i,
  input  wire logic signed [VAL_W-1:0] element_value_i,
  input  wire logic                    last_i,
  output      logic                    out_valid_o,
  input  wire logic                    out_stall_i,
  output      logic [HASH_W-1:0]       hash_bits_o
);

  logic              adv;
  logic              col_ok;
  logic              row_ok;
  srph_tok_t         head_tok;
  srph_tok_t         chain [HASH_COUNT+1];
  logic              out_valid_q;
  logic [HASH_W-1:0] hash_q;

  assign adv        = ~out_valid_q | ~out_stall_i;
  assign in_stall_o = ~adv;

  assign col_ok = 32'(element_index_i) < 32'(VECTOR_LENGTH);
  assign row_ok = 32'(hash_select_i) < 32'(HASH_COUNT);

  always_comb begin
    head_tok.vld   = in_valid_i;
    head_tok.func  = func_i;
    head_tok.row   = hash_select_i;
    head_tok.col   = element_index_i;
    head_tok.value = element_value_i;
    head_tok.last  = last_i;
    head_tok.hit   = (func_i == FUNC_ELEM) ? col_ok : (col_ok & row_ok);
    head_tok.hash  = '0;
  end

  assign chain[0] = head_tok;

  for (genvar k = 0; k < HASH_COUNT; k++) begin : g_cell
    logic [HASH_W-1:0] mask;
    if (k < HASH_W) begin : g_bit
      assign mask = HASH_W'(1) << k;
    end else begin : g_nobit
      assign mask = '0;
    end

    srph_cell u_cell (
      .clk_i (clk_i),
      .rst_ni(rst_ni),
      .adv_i (adv),
      .idx_i (IDX_W'(k)),
      .mask_i(mask),
      .tok_i (chain[k]),
      .tok_o (chain[k+1])
    );
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (adv) begin
      out_valid_q <= chain[HASH_COUNT].vld & (chain[HASH_COUNT].func == FUNC_ELEM) &
                     chain[HASH_COUNT].last;
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv) begin
      hash_q <= chain[HASH_COUNT].hash;
    end
  end

  assign out_valid_o = out_valid_q;
  assign hash_bits_o = hash_q;

endmodule

`default_nettype wire

@@ tb/sv/signed_random_projection_hash_checker.sv @@
`default_nettype none

module signed_random_projection_hash_checker import srph_pkg::*; (
  input  wire logic                    clk_i,
  input  wire logic                    rst_ni,
  input  wire logic                    in_valid_i,
  input  wire logic                    in_stall_i,
  input  wire logic                    func_i,
  input  wire logic [ROW_W-1:0]        hash_select_i,
  input  wire logic [COL_W-1:0]        element_index_i,
  input  wire logic signed [VAL_W-1:0] element_value_i,
  input  wire logic                    last_i,
  input  wire logic                    out_valid_i,
  input  wire logic                    out_stall_i,
  input  wire logic [HASH_W-1:0]       hash_bits_i,
  output int unsigned                  fail_count_o,
  output int unsigned                  pending_o
);

  localparam logic signed [ACC_W:0] SUM_MAX = {2'b00, {(ACC_W-1){1'b1}}};
  localparam logic signed [ACC_W:0] SUM_MIN = {2'b11, {(ACC_W-1){1'b0}}};

  logic signed [COEF_W-1:0] coef_mem [HASH_COUNT][VECTOR_LENGTH];
  logic signed [ACC_W-1:0]  row_sum [HASH_COUNT];
  logic [HASH_W-1:0]        hash_q [$];
  logic [HASH_W-1:0]        want_hash;
  int unsigned              fails = 0;

  // Apply one accepted item to the projection state, queue a hash on the last element.
  task automatic project_item();
    logic signed [PROD_W-1:0] prod;
    logic signed [ACC_W:0]    wide;
    logic [HASH_W-1:0]        word;
    if (func_i == FUNC_LOAD) begin
      if (hash_select_i < HASH_COUNT && element_index_i < VECTOR_LENGTH)
        coef_mem[hash_select_i][element_index_i] = element_value_i;
      return;
    end
    if (element_index_i < VECTOR_LENGTH) begin
      for (int k = 0; k < HASH_COUNT; k++) begin
        prod = coef_mem[k][element_index_i] * element_value_i;
        wide = row_sum[k] + prod;
        if (wide > SUM_MAX) wide = SUM_MAX;
        else if (wide < SUM_MIN) wide = SUM_MIN;
        row_sum[k] = wide[ACC_W-1:0];
      end
    end
    if (last_i) begin
      word = '0;
      for (int k = 0; k < HASH_COUNT; k++) begin
        if (k < HASH_W && row_sum[k] > 0) word[k] = 1'b1;
        row_sum[k] = '0;
      end
      hash_q.push_back(word);
    end
  endtask

  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int k = 0; k < HASH_COUNT; k++) row_sum[k] = '0;
      hash_q.delete();
      fail_count_o <= 0;
      pending_o <= 0;
    end else begin
      if (out_valid_i && !out_stall_i) begin
        if (hash_q.size() == 0) begin
          $error("hash_bits: no item expected, actual %h", hash_bits_i);
          fails++;
        end else begin
          want_hash = hash_q.pop_front();
          if (want_hash !== hash_bits_i) begin
            $error("hash_bits: expected %h, actual %h", want_hash, hash_bits_i);
            fails++;
          end
        end
      end
      if (in_valid_i && !in_stall_i) project_item();
      pending_o <= hash_q.size();
      fail_count_o <= fails;
    end
  end

endmodule

`default_nettype wire

@@ tb/sv/signed_random_projection_hash_unit_tb.sv @@
`default_nettype none

module signed_random_projection_hash_unit_tb;
  import srph_pkg::*;

  localparam int DRAIN_CYCLES = 3 * HASH_COUNT + 32;

  logic                    clk = 1'b0;
  logic                    rst_n = 1'b0;
  logic                    in_valid = 1'b0;
  logic                    in_stall;
  logic                    func = FUNC_LOAD;
  logic [ROW_W-1:0]        hash_select = '0;
  logic [COL_W-1:0]        element_index = '0;
  logic signed [VAL_W-1:0] element_value = '0;
  logic                    last = 1'b0;
  logic                    out_valid;
  logic                    out_stall = 1'b0;
  logic [HASH_W-1:0]       hash_bits;
  int unsigned             fail_count;
  int unsigned             pending;

  int send_idle_pct = 0;
  int recv_stall_pct = 0;
  bit coef_written [HASH_COUNT][VECTOR_LENGTH];
  int rows_loaded [VECTOR_LENGTH];
  int ready_cols [$];
  int n_loads = 0;
  int n_elems = 0;
  int n_vectors = 0;

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  signed_random_projection_hash_unit i_dut (
    .clk_i           (clk),
    .rst_ni          (rst_n),
    .in_valid_i      (in_valid),
    .in_stall_o      (in_stall),
    .func_i          (func),
    .hash_select_i   (hash_select),
    .element_index_i (element_index),
    .element_value_i (element_value),
    .last_i          (last),
    .out_valid_o     (out_valid),
    .out_stall_i     (out_stall),
    .hash_bits_o     (hash_bits)
  );

  signed_random_projection_hash_checker i_chk (
    .clk_i           (clk),
    .rst_ni          (rst_n),
    .in_valid_i      (in_valid),
    .in_stall_i      (in_stall),
    .func_i          (func),
    .hash_select_i   (hash_select),
    .element_index_i (element_index),
    .element_value_i (element_value),
    .last_i          (last),
    .out_valid_i     (out_valid),
    .out_stall_i     (out_stall),
    .hash_bits_i     (hash_bits),
    .fail_count_o    (fail_count),
    .pending_o       (pending)
  );

  always @(negedge clk) begin
    out_stall <= ($urandom_range(99) < recv_stall_pct);
  end

  initial begin
    #20_000_000;
    $display("SCOREBOARD MISMATCH");
    $finish;
  end

  // Called at a falling edge; returns at the falling edge after acceptance.
  task automatic drive_item(input logic f, input logic [ROW_W-1:0] r,
                            input logic [COL_W-1:0] c, input logic signed [VAL_W-1:0] v,
                            input logic l);
    while ($urandom_range(99) < send_idle_pct) begin
      in_valid <= 1'b0;
      @(negedge clk);
    end
    in_valid <= 1'b1;
    func <= f;
    hash_select <= r;
    element_index <= c;
    element_value <= v;
    last <= l;
    do @(posedge clk); while (in_stall);
    @(negedge clk);
  endtask

  // Track which columns are loaded in every row; only those may be projected.
  task automatic load_coef(input int r, input int c, input logic signed [VAL_W-1:0] v,
                           input logic l);
    drive_item(FUNC_LOAD, r[ROW_W-1:0], c[COL_W-1:0], v, l);
    n_loads++;
    if (r < HASH_COUNT && c < VECTOR_LENGTH && !coef_written[r][c]) begin
      coef_written[r][c] = 1'b1;
      rows_loaded[c]++;
      if (rows_loaded[c] == HASH_COUNT) ready_cols.push_back(c);
    end
  endtask

  task automatic feed_element(input int c, input logic signed [VAL_W-1:0] v, input logic l);
    drive_item(FUNC_ELEM, ROW_W'($urandom()), c[COL_W-1:0], v, l);
    n_elems++;
    if (l) n_vectors++;
  endtask

  function automatic logic signed [VAL_W-1:0] pick_value();
    case ($urandom_range(7))
      0: return 16'sh7FFF;
      1: return 16'sh8000;
      2: return $urandom_range(1) ? 16'sh0001 : 16'shFFFF;
      default: return VAL_W'($urandom());
    endcase
  endfunction

  function automatic int pick_ready();
    return ready_cols[$urandom_range(ready_cols.size() - 1)];
  endfunction

  task automatic fill_column(input int c);
    for (int r = 0; r < HASH_COUNT; r++) load_coef(r, c, pick_value(), $urandom_range(1));
  endtask

  // Hold the sender until every queued hash has been delivered.
  task automatic wait_drained();
    in_valid <= 1'b0;
    do @(negedge clk); while (pending != 0);
  endtask

  task automatic random_phase(input int idle_pct, input int stall_pct, input int n_items);
    int done;
    int len;
    int roll;
    done = 0;
    send_idle_pct = idle_pct;
    recv_stall_pct = stall_pct;
    while (done < n_items) begin
      roll = $urandom_range(99);
      if (roll < 70) begin
        len = $urandom_range(1, 6);
        for (int i = 0; i < len; i++) feed_element(pick_ready(), pick_value(), i == len - 1);
        done += len;
      end else if (roll < 82) begin
        load_coef($urandom_range(HASH_COUNT - 1), pick_ready(), pick_value(),
                  $urandom_range(1));
        done++;
      end else if (roll < 92) begin
        load_coef($urandom_range((1 << ROW_W) - 1), $urandom_range((1 << COL_W) - 1),
                  pick_value(), $urandom_range(1));
        done++;
      end else if (roll < 95) begin
        fill_column($urandom_range(VECTOR_LENGTH - 1));
        done += HASH_COUNT;
      end else begin
        // Break a vector with a coefficient rewrite; the next vector continues the sums.
        len = $urandom_range(1, 3);
        for (int i = 0; i < len; i++) feed_element(pick_ready(), pick_value(), 1'b0);
        load_coef($urandom_range(HASH_COUNT - 1), pick_ready(), pick_value(), 1'b1);
        done += len + 1;
      end
    end
    wait_drained();
  endtask

  initial begin
    repeat (9) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    // Column 0 alternates full-scale coefficients.
    for (int r = 0; r < HASH_COUNT; r++)
      load_coef(r, 0, (r % 2) ? 16'sh7FFF : 16'sh8000, 1'b0);
    fill_column(VECTOR_LENGTH - 1);
    for (int b = 0; b < COL_W; b++) fill_column(1 << b);

    feed_element(0, 16'sh7FFF, 1'b1);
    feed_element(0, 16'sh8000, 1'b1);
    feed_element(VECTOR_LENGTH - 1, 16'sh0000, 1'b1);
    // Exact cancellation leaves zero sums, which hash to zero bits.
    feed_element(512, 16'sh0001, 1'b0);
    feed_element(512, 16'shFFFF, 1'b1);
    load_coef(0, 1, 16'sh7FFF, 1'b1);
    load_coef(HASH_COUNT - 1, 1, 16'sh8000, 1'b0);
    feed_element(1, 16'sh0100, 1'b1);
    load_coef(5, 2, 16'sh0000, 1'b0);
    feed_element(2, 16'sh8000, 1'b0);
    load_coef(6, 4, 16'sh0001, 1'b1);
    feed_element(4, 16'sh7FFF, 1'b0);
    feed_element(VECTOR_LENGTH - 1, -16'sd256, 1'b1);
    feed_element(8, 16'sh0001, 1'b1);
    feed_element(256, 16'shFFFF, 1'b1);
    wait_drained();

    random_phase(0, 0, 200);
    random_phase(84, 0, 200);
    random_phase(0, 84, 200);
    random_phase(16, 16, 200);

    send_idle_pct = 0;
    recv_stall_pct = 0;
    wait_drained();
    repeat (DRAIN_CYCLES) @(posedge clk);

    $display("Covered %0d coefficient loads and %0d elements in %0d hashed vectors,",
             n_loads, n_elems, n_vectors);
    $display("with full-scale values, vector breaks and all sender and receiver pacing modes.");
    if (fail_count == 0) begin
      $display("SCOREBOARD CLEAN");
    end else begin
      $display("SCOREBOARD MISMATCH");
    end
    $finish;
  end

endmodule

`default_nettype wire
